/* hw/rtl/bpc_pkg.sv */
// Balance PID controller package: widths, register indexes, reset values,
// microcode word type and the control program ROM.
// No dependencies.
package bpc_pkg;

    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int SUM_W      = 20;
    localparam int SLOPE_W    = 20;
    localparam int OUT_W      = 18;
    localparam int CTL_W      = 17;
    localparam int SPD_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int LIMO_W     = 16;
    localparam int LIMI_W     = 19;
    localparam int TILT_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int MA_W       = 20;
    localparam int MB_W       = 16;
    localparam int PROD_W     = 36;
    localparam int ACC_W      = 37;
    localparam int FRAC       = 12;
    localparam int SCALE_W    = 19;
    localparam int SCALE_SH   = 9;

    localparam logic signed [MB_W-1:0] FILT_NEW = 16'sd819;
    localparam logic signed [MB_W-1:0] FILT_OLD = 16'sd3277;
    localparam logic [SPD_W-1:0]       DEADZONE = 10'd30;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANTI_WIND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIM  = 3'd7;

    localparam logic signed [ANGLE_W-1:0] RST_SETPOINT = 16'sd0;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_P   = 16'sd6400;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_I   = 16'sd128;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_D   = 16'sd1280;
    localparam logic [LIMO_W-1:0]         RST_OUT_LIM  = 16'd65280;
    localparam logic [LIMI_W-1:0]         RST_INT_LIM  = 19'd409600;
    localparam logic                      RST_ANTI_WIND = 1'b1;
    localparam logic [TILT_W-1:0]         RST_TILT_LIM = 15'd2130;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_INTEG,
        ST_SLOPE_OLD,
        ST_SLOPE,
        ST_TERM_I,
        ST_TERM_D,
        ST_SUM,
        ST_CLAMP,
        ST_OUT,
        ST_STOP
    } t_step;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_DIFF,
        MS_SLOPE,
        MS_P,
        MS_I,
        MS_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        AO_HOLD,
        AO_PROD,
        AO_SHR,
        AO_ADD_SHR
    } t_acc_op;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_IN,
        JC_STOP,
        JC_OUT
    } t_jump;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     wr_integ;
        logic     wr_slope;
        logic     wr_ctl;
        logic     out_stop;
        t_jump    jump;
        t_step    next;
        t_step    alt;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, JC_NONE, ST_IDLE, ST_IDLE};
        case (step)
            ST_IDLE:      w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_IN, ST_TEST, ST_IDLE};
            ST_TEST:      w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_STOP, ST_INTEG, ST_STOP};
            ST_INTEG:     w = '{MS_DIFF, AO_HOLD, 1'b1, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_SLOPE_OLD, ST_IDLE};
            ST_SLOPE_OLD: w = '{MS_SLOPE, AO_PROD, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_SLOPE, ST_IDLE};
            ST_SLOPE:     w = '{MS_P, AO_HOLD, 1'b0, 1'b1, 1'b0, 1'b0,
                                JC_NONE, ST_TERM_I, ST_IDLE};
            ST_TERM_I:    w = '{MS_I, AO_SHR, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_TERM_D, ST_IDLE};
            ST_TERM_D:    w = '{MS_D, AO_ADD_SHR, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_SUM, ST_IDLE};
            ST_SUM:       w = '{MS_NONE, AO_ADD_SHR, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_CLAMP, ST_IDLE};
            ST_CLAMP:     w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b1, 1'b0,
                                JC_NONE, ST_OUT, ST_IDLE};
            ST_OUT:       w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_OUT, ST_IDLE, ST_IDLE};
            ST_STOP:      w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b1,
                                JC_OUT, ST_IDLE, ST_IDLE};
            default:      w = '{MS_NONE, AO_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                JC_NONE, ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/balance_pid_controller.sv */
// Balance PID controller top level: microcoded sequencer over one shared
// multiplier, accumulator and output register. Depends on bpc_pkg.
// A result is registered in step ST_OUT at the end of the program, or in
// ST_STOP on a tilt stop. A new request is taken only once the program is
// back in ST_IDLE (one shared multiplier); a stalled result holds the program.
// Reset (synchronous, active low) restores register defaults and clears state.
module balance_pid_controller (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [bpc_pkg::ANGLE_W-1:0]      i_angle,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [bpc_pkg::CTL_W-1:0]        o_control_out,
    output logic signed [bpc_pkg::SPD_W-1:0]        o_left_speed,
    output logic signed [bpc_pkg::SPD_W-1:0]        o_right_speed,
    output logic                                    o_tilt_stop,
    input  logic                                    i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import bpc_pkg::*;

    logic signed [ANGLE_W-1:0] r_setpoint;
    logic signed [GAIN_W-1:0]  r_gain_p;
    logic signed [GAIN_W-1:0]  r_gain_i;
    logic signed [GAIN_W-1:0]  r_gain_d;
    logic [LIMO_W-1:0]         r_output_limit;
    logic [LIMI_W-1:0]         r_integral_limit;
    logic                      r_anti_windup;
    logic [TILT_W-1:0]         r_tilt_limit;

    logic signed [SUM_W-1:0]   r_error_sum;
    logic signed [ERR_W-1:0]   r_last_error;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [OUT_W-1:0]   r_last_output;

    t_step                     r_step;
    t_step                     n_step;
    t_uword                    uw;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_stop;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      r_out_valid;
    logic signed [CTL_W-1:0]   r_control_out;
    logic signed [SPD_W-1:0]   r_left_speed;
    logic signed [SPD_W-1:0]   r_right_speed;
    logic                      r_tilt_stop;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_ld;
    logic [ANGLE_W:0]          angle_mag;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [PROD_W-1:0]  prod_shr;
    logic signed [ACC_W-1:0]   slope_sum;
    logic signed [SUM_W:0]     int_sum;
    logic signed [SUM_W:0]     int_lim;
    logic signed [SUM_W-1:0]   int_next;
    logic [OUT_W-1:0]          last_mag;
    logic                      integ_en;
    logic signed [ACC_W-1:0]   out_lim;
    logic signed [ACC_W-1:0]   ctl_c;
    logic [SCALE_W-1:0]        scaled;
    logic [SPD_W-1:0]          speed_q;
    logic [SPD_W-1:0]          speed_dz;
    logic signed [SPD_W-1:0]   left_c;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_step != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_ld     = (uw.jump == JC_OUT) && out_free;

    // control word fetch
    always_comb begin
        uw = ucode(r_step);
    end

    // sequencer next step
    always_comb begin
        case (uw.jump)
            JC_NONE: n_step = uw.next;
            JC_IN:   n_step = in_acc ? uw.next : r_step;
            JC_STOP: n_step = r_stop ? uw.alt : uw.next;
            JC_OUT:  n_step = out_free ? uw.next : r_step;
            default: n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint       <= RST_SETPOINT;
            r_gain_p         <= RST_GAIN_P;
            r_gain_i         <= RST_GAIN_I;
            r_gain_d         <= RST_GAIN_D;
            r_output_limit   <= RST_OUT_LIM;
            r_integral_limit <= RST_INT_LIM;
            r_anti_windup    <= RST_ANTI_WIND;
            r_tilt_limit     <= RST_TILT_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SETPOINT:  r_setpoint       <= i_cfg_data[ANGLE_W-1:0];
                REG_GAIN_P:    r_gain_p         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    r_gain_i         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    r_gain_d         <= i_cfg_data[GAIN_W-1:0];
                REG_OUT_LIM:   r_output_limit   <= i_cfg_data[LIMO_W-1:0];
                REG_INT_LIM:   r_integral_limit <= i_cfg_data[LIMI_W-1:0];
                REG_ANTI_WIND: r_anti_windup    <= i_cfg_data[0];
                REG_TILT_LIM:  r_tilt_limit     <= i_cfg_data[TILT_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    assign angle_mag = i_angle[ANGLE_W-1] ? (ANGLE_W+1)'(-(ANGLE_W+1)'(i_angle))
                                          : (ANGLE_W+1)'(i_angle);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err  <= ERR_W'(r_setpoint) - ERR_W'(i_angle);
            r_stop <= angle_mag > (ANGLE_W+1)'(r_tilt_limit);
        end
    end

    // shared multiplier
    assign diff = DIFF_W'(r_err) - DIFF_W'(r_last_error);

    always_comb begin
        case (uw.mul_sel)
            MS_DIFF:  begin mul_a = MA_W'(diff);        mul_b = FILT_NEW; end
            MS_SLOPE: begin mul_a = r_slope;            mul_b = FILT_OLD; end
            MS_P:     begin mul_a = MA_W'(r_err);       mul_b = r_gain_p; end
            MS_I:     begin mul_a = r_error_sum;        mul_b = r_gain_i; end
            MS_D:     begin mul_a = r_slope;            mul_b = r_gain_d; end
            default:  begin mul_a = '0;                 mul_b = '0;       end
        endcase
    end

    assign prod_c   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_shr = r_prod >>> FRAC;

    always_ff @(posedge i_clk) begin
        if (uw.mul_sel != MS_NONE) begin
            r_prod <= prod_c;
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.acc_op)
            AO_PROD:    r_acc <= ACC_W'(r_prod);
            AO_SHR:     r_acc <= ACC_W'(prod_shr);
            AO_ADD_SHR: r_acc <= r_acc + ACC_W'(prod_shr);
            default:    r_acc <= r_acc;
        endcase
    end

    // integrator with anti-windup and clamp
    assign last_mag = r_last_output[OUT_W-1] ? OUT_W'(-r_last_output)
                                             : OUT_W'(r_last_output);
    assign integ_en = !r_anti_windup || (last_mag < OUT_W'(r_output_limit));
    assign int_sum  = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(r_err);
    assign int_lim  = (SUM_W+1)'(r_integral_limit);

    always_comb begin
        if (int_sum > int_lim) begin
            int_next = SUM_W'(int_lim);
        end else if (int_sum < -int_lim) begin
            int_next = SUM_W'(-int_lim);
        end else begin
            int_next = SUM_W'(int_sum);
        end
    end

    assign slope_sum = r_acc + ACC_W'(r_prod);

    // output clamp
    assign out_lim = ACC_W'(r_output_limit);

    always_comb begin
        if (r_acc > out_lim) begin
            ctl_c = out_lim;
        end else if (r_acc < -out_lim) begin
            ctl_c = -out_lim;
        end else begin
            ctl_c = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum   <= '0;
            r_last_error  <= '0;
            r_slope       <= '0;
            r_last_output <= '0;
        end else begin
            if (uw.wr_integ && integ_en) begin
                r_error_sum <= int_next;
            end
            if (uw.wr_slope) begin
                r_slope <= SLOPE_W'(slope_sum >>> FRAC);
            end
            if (uw.wr_ctl) begin
                r_last_output <= OUT_W'(ctl_c);
                r_last_error  <= r_err;
            end
        end
    end

    // motor scaling by 3/512 with deadzone
    assign scaled   = SCALE_W'({last_mag[CTL_W-1:0], 1'b0}) + SCALE_W'(last_mag[CTL_W-1:0]);
    assign speed_q  = scaled[SCALE_W-1:SCALE_SH];
    assign speed_dz = (speed_q < DEADZONE) ? '0 : speed_q;
    assign left_c   = r_last_output[OUT_W-1] ? SPD_W'(-speed_dz) : SPD_W'(speed_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_control_out <= r_last_output[CTL_W-1:0];
            r_tilt_stop   <= uw.out_stop;
            if (uw.out_stop) begin
                r_left_speed  <= '0;
                r_right_speed <= '0;
            end else begin
                r_left_speed  <= left_c;
                r_right_speed <= -left_c;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_control_out;
    assign o_left_speed  = r_left_speed;
    assign o_right_speed = r_right_speed;
    assign o_tilt_stop   = r_tilt_stop;

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tilt_stop) |-> (o_left_speed == '0 && o_right_speed == '0))
        else $error("stop result with non-zero motor command");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_right_speed == SPD_W'(-o_left_speed)))
        else $error("right motor not the negation of left");

    a_deadzone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_left_speed != '0) |->
        (o_left_speed >= $signed(SPD_W'(DEADZONE)) ||
         o_left_speed <= -$signed(SPD_W'(DEADZONE))))
        else $error("motor command inside deadzone");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_step == ST_TEST))
        else $error("accepted request did not start the program");

endmodule
